@@ rtl/palette_store_nearest_color_defines.svh @@
// Assertion macros for the palette store and nearest-color search block.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef PALETTE_STORE_NEAREST_COLOR_DEFINES_SVH
`define PALETTE_STORE_NEAREST_COLOR_DEFINES_SVH

// same-cycle implication
`define PNC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PNC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pnc_pkg.sv @@
// Shared types and constants for the palette store and nearest-color search.
// No dependencies.
package pnc_pkg;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam int unsigned CH_W   = 8;
  localparam int unsigned SQ_W   = 2 * CH_W;
  localparam int unsigned DIST_W = SQ_W + 2;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [CH_W-1:0] entry_index;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0] best_index;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
  } out_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [SQ_W-1:0] sq_r;
    logic [SQ_W-1:0] sq_g;
    logic [SQ_W-1:0] sq_b;
  } sq_t;

endpackage

@@ rtl/pnc_dist.sv @@
// Per-channel squared differences between a target color and a palette entry.
// Depends on pnc_pkg.
module pnc_dist
  import pnc_pkg::*;
(
  input  rgb_t target_i,
  input  rgb_t entry_i,
  output sq_t  sq_o
);

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    logic [CH_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  assign sq_o.sq_r = sq_diff(target_i.red,   entry_i.red);
  assign sq_o.sq_g = sq_diff(target_i.green, entry_i.green);
  assign sq_o.sq_b = sq_diff(target_i.blue,  entry_i.blue);

endmodule

@@ rtl/palette_store_nearest_color.sv @@
// Lookup returns the addressed entry; search compares the palette entries in order and
// ends early at the first exact match, one palette read per cycle from the single-port store.
// A write completes on accept and leaves the block idle.
// One item in work at a time: the next is taken once the result is in the output register.
// Reset clears control state and the per-entry valid bits, so every entry reads as zero.
// Depends on pnc_pkg, pnc_dist and palette_store_nearest_color_defines.svh.
`include "palette_store_nearest_color_defines.svh"

module palette_store_nearest_color
  import pnc_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned IDX_W = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(PALETTE_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOK   = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  p1_v_q, p1_v_d, p2_v_q, p2_v_d;
  logic                  best_set_q, best_set_d;
  logic                  out_valid_q, out_valid_d;
  logic [PALETTE_ENTRIES-1:0] vld_q, vld_d;

  logic [23:0]           mem_q [PALETTE_ENTRIES];
  logic [23:0]           rd_data_q;
  logic                  rd_vld_q;

  rgb_t                  tgt_q, tgt_d;
  logic [CH_W-1:0]       idx_q, idx_d;
  logic                  look_ok_q, look_ok_d;
  logic [IDX_W-1:0]      p1_idx_q, p1_idx_d, p2_idx_q;
  sq_t                   p2_sq_q, sq;
  rgb_t                  p2_col_q;
  logic [CH_W-1:0]       best_idx_q, best_idx_d;
  rgb_t                  best_col_q, best_col_d;
  logic [DIST_W-1:0]     best_dist_q, best_dist_d, dist_sum;
  out_t                  out_q, out_d;

  logic                  accept, idx_ok, out_free, issue;
  logic                  wr_en, rd_en;
  logic [IDX_W-1:0]      wr_addr, rd_addr;
  rgb_t                  entry_col;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign idx_ok     = (9'(in_data_i.entry_index) < 9'(PALETTE_ENTRIES));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign issue      = (state_q == ST_SEARCH) && (cnt_q < CNT_W'(PALETTE_ENTRIES));
  assign entry_col  = rd_vld_q ? rgb_t'(rd_data_q) : '0;
  assign wr_addr    = in_data_i.entry_index[IDX_W-1:0];
  assign dist_sum   = DIST_W'(p2_sq_q.sq_r) + DIST_W'(p2_sq_q.sq_g) + DIST_W'(p2_sq_q.sq_b);

  pnc_dist u_dist (
    .target_i (tgt_q),
    .entry_i  (entry_col),
    .sq_o     (sq)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    best_set_d  = best_set_q;
    best_idx_d  = best_idx_q;
    best_col_d  = best_col_q;
    best_dist_d = best_dist_q;
    tgt_d       = tgt_q;
    idx_d       = idx_q;
    look_ok_d   = look_ok_q;
    vld_d       = vld_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = cnt_q[IDX_W-1:0];
    p1_v_d      = issue;
    p1_idx_d    = cnt_q[IDX_W-1:0];
    p2_v_d      = p1_v_q && (state_q == ST_SEARCH);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_data_i.opcode)
            OP_WRITE: begin
              if (idx_ok) begin
                wr_en          = 1'b1;
                vld_d[wr_addr] = 1'b1;
              end
            end
            OP_LOOKUP: begin
              rd_en     = 1'b1;
              rd_addr   = wr_addr;
              idx_d     = in_data_i.entry_index;
              look_ok_d = idx_ok;
              state_d   = ST_LOOK;
            end
            OP_SEARCH: begin
              tgt_d      = '{in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
              cnt_d      = '0;
              best_set_d = 1'b0;
              state_d    = ST_SEARCH;
            end
            default: ;
          endcase
        end
      end
      ST_LOOK: begin
        best_idx_d = idx_q;
        best_col_d = look_ok_q ? entry_col : '0;
        state_d    = ST_DONE;
      end
      ST_SEARCH: begin
        if (issue) begin
          rd_en = 1'b1;
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (p2_v_q && (!best_set_q || dist_sum < best_dist_q)) begin
          best_set_d  = 1'b1;
          best_idx_d  = CH_W'(p2_idx_q);
          best_col_d  = p2_col_q;
          best_dist_d = dist_sum;
          if (dist_sum == '0) begin
            state_d = ST_DONE;
          end
        end
        if (!issue && !p1_v_q && !p2_v_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{best_idx_q, best_col_q.red, best_col_q.green, best_col_q.blue};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      best_set_q  <= 1'b0;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      p1_v_q      <= p1_v_d;
      p2_v_q      <= p2_v_d;
      best_set_q  <= best_set_d;
      out_valid_q <= out_valid_d;
      vld_q       <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q       <= tgt_d;
    idx_q       <= idx_d;
    look_ok_q   <= look_ok_d;
    p1_idx_q    <= p1_idx_d;
    p2_idx_q    <= p1_idx_q;
    p2_sq_q     <= sq;
    p2_col_q    <= entry_col;
    best_idx_q  <= best_idx_d;
    best_col_q  <= best_col_d;
    best_dist_q <= best_dist_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PNC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(PALETTE_ENTRIES), "search count overran")
  `PNC_ASSERT_NXT(a_match_exit, (state_q == ST_SEARCH) && p2_v_q && (dist_sum == '0),
                  state_q == ST_DONE, "exact match did not end search")
  `PNC_ASSERT_IMP(a_out_from_done, $rose(out_valid_o), $past(state_q) == ST_DONE,
                  "result appeared without a finished item")
  `PNC_ASSERT_IMP(a_p2_follows_p1, p2_v_q, $past(p1_v_q), "compare stage without a read")

endmodule
